// ----- src/ungapped_seed_extension_top_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the ungapped seed extension block
// Concurrent checks clocked on clk and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef UNGAPPED_SEED_EXTENSION_TOP_MACROS_SVH
`define UNGAPPED_SEED_EXTENSION_TOP_MACROS_SVH

// Same-cycle implication
`define USEXT_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication
`define USEXT_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- src/usext_pkg.sv -----
// ----------------------------------------------------------------------------
// usext_pkg
// Types and constants shared by the ungapped seed extension modules.
// ----------------------------------------------------------------------------
package usext_pkg;

	localparam int unsigned POS_BITS = 32;
	localparam int unsigned RUN_W    = 34;

	localparam logic [31:0] POS_MASK =
		(POS_BITS >= 32) ? 32'hFFFF_FFFF : 32'((64'd1 << POS_BITS) - 64'd1);

	localparam logic [7:0] BASE_N = 8'h4E;
	localparam logic [7:0] BASE_A = 8'h41;
	localparam logic [7:0] BASE_C = 8'h43;
	localparam logic [7:0] BASE_G = 8'h47;
	localparam logic [7:0] BASE_T = 8'h54;

	localparam logic [RUN_W-1:0] RUN_MAX = {2'b01, {(RUN_W-2){1'b1}}};

	typedef struct packed {
		logic [7:0]  x_base;
		logic [7:0]  y_base;
		logic [31:0] x_pos;
		logic [31:0] y_pos;
		logic        leftward;
		logic        phase_start;
		logic        phase_end;
		logic        reverse_strand;
	} pair_t;

	typedef struct packed {
		logic [31:0] seg_x_start;
		logic [31:0] seg_y_start;
		logic [31:0] seg_length;
		logic [31:0] seg_score;
	} seg_t;

	// Result of one scoring step handed to the output stage
	typedef struct packed {
		logic emit;
		seg_t seg;
	} core_res_t;

	// Complement a base: A<->T, C<->G, anything else unchanged
	function automatic logic [7:0] complement_base(input logic [7:0] c);
		logic [7:0] r;
		case (c)
			BASE_A:  r = BASE_T;
			BASE_T:  r = BASE_A;
			BASE_C:  r = BASE_G;
			BASE_G:  r = BASE_C;
			default: r = c;
		endcase
		return r;
	endfunction

endpackage

// ----- src/usext_match.sv -----
// ----------------------------------------------------------------------------
// usext_match
// Base-pair compare: match when neither base is N and the bases agree,
// against the complement of y on the reverse strand.
// ----------------------------------------------------------------------------
module usext_match (
	input  logic [7:0] x_base,
	input  logic [7:0] y_base,
	input  logic       strand,
	output logic       match
);

	logic [7:0] y_cmp;

	// Select the compared y base
	assign y_cmp = strand ? usext_pkg::complement_base(y_base) : y_base;

	// Reject N on either side
	assign match = (x_base != usext_pkg::BASE_N) && (y_base != usext_pkg::BASE_N) &&
		(x_base == y_cmp);

endmodule

// ----- src/usext_core.sv -----
// ----------------------------------------------------------------------------
// usext_core
// Extension state: running score, best score and best segment bounds.
// Advances one pair per enabled cycle and forms the result combinationally.
// ----------------------------------------------------------------------------
module usext_core (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 step,
	input  usext_pkg::pair_t     pair_s1,
	output usext_pkg::core_res_t res
);

	localparam int unsigned RW = usext_pkg::RUN_W;

	logic [RW-1:0] run_q;
	logic [31:0]   top_q;
	logic [31:0]   x_start_q;
	logic [31:0]   x_end_q;
	logic [31:0]   y_start_q;
	logic          strand_q;

	logic [31:0]   xp;
	logic [31:0]   yp;
	logic          right_start;
	logic [RW-1:0] run_base;
	logic [31:0]   top_base;
	logic [31:0]   x_start_base;
	logic [31:0]   x_end_base;
	logic [31:0]   y_start_base;
	logic          strand_base;
	logic          match;
	logic [RW-1:0] run_next;
	logic          better;
	logic [31:0]   top_next;
	logic [31:0]   x_start_next;
	logic [31:0]   x_end_next;
	logic [31:0]   y_start_next;

	usext_match u_match (
		.x_base (pair_s1.x_base),
		.y_base (pair_s1.y_base),
		.strand (strand_base),
		.match  (match)
	);

	// Mask positions and apply phase start
	always_comb begin
		xp           = pair_s1.x_pos & usext_pkg::POS_MASK;
		yp           = pair_s1.y_pos & usext_pkg::POS_MASK;
		right_start  = pair_s1.phase_start && !pair_s1.leftward;
		run_base     = run_q;
		top_base     = top_q;
		x_start_base = x_start_q;
		x_end_base   = x_end_q;
		y_start_base = y_start_q;
		strand_base  = strand_q;
		if (right_start) begin
			run_base     = '0;
			top_base     = '0;
			x_start_base = xp;
			x_end_base   = xp;
			y_start_base = yp;
			strand_base  = pair_s1.reverse_strand;
		end else if (pair_s1.phase_start) begin
			run_base = {2'b00, top_q};
		end
	end

	// Score the pair and track the best segment; skip once the score is negative
	always_comb begin
		run_next     = run_base;
		better       = 1'b0;
		top_next     = top_base;
		x_start_next = x_start_base;
		x_end_next   = x_end_base;
		y_start_next = y_start_base;
		if (!run_base[RW-1]) begin
			if (match) begin
				if (run_base != usext_pkg::RUN_MAX) begin
					run_next = run_base + RW'(1);
				end
			end else begin
				run_next = run_base - RW'(1);
			end
			better = !run_next[RW-1] && (run_next >= {2'b00, top_base});
			if (better) begin
				top_next = run_next[RW-2] ? 32'hFFFF_FFFF : run_next[31:0];
				if (!pair_s1.leftward) begin
					x_end_next = xp;
					if (strand_base) begin
						y_start_next = yp;
					end
				end else begin
					x_start_next = xp;
					if (!strand_base) begin
						y_start_next = yp;
					end
				end
			end
		end
	end

	// Form the result from the updated state
	always_comb begin
		res.emit            = pair_s1.phase_end && pair_s1.leftward;
		res.seg.seg_x_start = x_start_next;
		res.seg.seg_y_start = y_start_next;
		res.seg.seg_length  = x_end_next - x_start_next + 32'd1;
		res.seg.seg_score   = top_next;
	end

	// Commit the state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q     <= '0;
			top_q     <= '0;
			x_start_q <= '0;
			x_end_q   <= '0;
			y_start_q <= '0;
			strand_q  <= 1'b0;
		end else if (step) begin
			run_q     <= run_next;
			top_q     <= top_next;
			x_start_q <= x_start_next;
			x_end_q   <= x_end_next;
			y_start_q <= y_start_next;
			strand_q  <= strand_base;
		end
	end

endmodule

// ----- src/ungapped_seed_extension_top.sv -----
// ----------------------------------------------------------------------------
// ungapped_seed_extension_top
// A closing pair is registered in stage one; its result is then registered in the output register.
// Throughput: one pair per cycle, set by the score update loop.
// A stall occurs only while a finished result waits and the next one is due.
// Reset: arst_n clears all scores, bounds, strand and valid flags at once.
// ----------------------------------------------------------------------------
`include "ungapped_seed_extension_top_macros.svh"

module ungapped_seed_extension_top (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              pair_valid,
	output logic              pair_ready,
	input  usext_pkg::pair_t  pair,
	output logic              seg_valid,
	input  logic              seg_ready,
	output usext_pkg::seg_t   seg
);

	logic                 s1_valid_q;
	usext_pkg::pair_t     pair_s1;
	usext_pkg::core_res_t res;
	logic                 advance;
	logic                 step;
	logic                 seg_valid_q;
	usext_pkg::seg_t      seg_q;

	// Hold the pair in stage one only while its result cannot be placed
	assign advance    = !res.emit || !seg_valid_q || seg_ready;
	assign step       = s1_valid_q && advance;
	assign pair_ready = !s1_valid_q || advance;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (pair_ready) begin
			s1_valid_q <= pair_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (pair_ready && pair_valid) begin
			pair_s1 <= pair;
		end
	end

	usext_core u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (step),
		.pair_s1 (pair_s1),
		.res     (res)
	);

	// Result register: load on a closing pair, drop on transaction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seg_valid_q <= 1'b0;
		end else if (step && res.emit) begin
			seg_valid_q <= 1'b1;
		end else if (seg_ready) begin
			seg_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step && res.emit) begin
			seg_q <= res.seg;
		end
	end

	assign seg_valid = seg_valid_q;
	assign seg       = seg_q;

	`USEXT_ASSERT_NOW(a_stall_cause, s1_valid_q && !advance, seg_valid_q && !seg_ready && res.emit, "stage one stalled without a pending result")
	`USEXT_ASSERT_NEXT(a_result_loaded, step && res.emit, seg_valid, "closing pair did not produce a result")
	`USEXT_ASSERT_NOW(a_ready_when_empty, !s1_valid_q, pair_ready, "input not ready with empty stage one")
	`USEXT_ASSERT_NEXT(a_no_spurious, !seg_valid_q && !(step && res.emit), !seg_valid, "result appeared without a closing pair")

endmodule

// ----- tb/sv/ungapped_seed_extension_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Ungapped seed extension checker
// Watches the pair and segment channels. Each accepted pair transaction goes
// through a local model of the diagonal scoring, and the segment it closes is
// queued. Each accepted segment transaction is compared field by field with
// the oldest queued segment.
// ----------------------------------------------------------------------------
module ungapped_seed_extension_checker
	import usext_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  pair_valid,
	input  logic  pair_ready,
	input  pair_t pair,
	input  logic  seg_valid,
	input  logic  seg_ready,
	input  seg_t  seg,
	output int    mismatches,
	output int    segs_pending
);

	// Model state: running score, best score and bounds of the best segment
	logic signed [RUN_W-1:0] run_level;
	logic [31:0]             peak_score;
	logic [31:0]             best_x_lo;
	logic [31:0]             best_x_hi;
	logic [31:0]             best_y_lo;
	logic                    rev_strand;
	seg_t                    segs_due[$];

	// Watson-Crick partner of a base; other characters map to themselves
	function automatic logic [7:0] opposite_base(input logic [7:0] b);
		logic [7:0] r;
		r = b;
		if (b == BASE_A) r = BASE_T;
		if (b == BASE_T) r = BASE_A;
		if (b == BASE_C) r = BASE_G;
		if (b == BASE_G) r = BASE_C;
		return r;
	endfunction

	// Score one pair and queue the segment when a leftward phase closes
	task automatic extend_diagonal(input pair_t p);
		logic [31:0] xp;
		logic [31:0] yp;
		logic [7:0]  y_cmp;
		logic        hit;
		seg_t        s;
		xp = p.x_pos & POS_MASK;
		yp = p.y_pos & POS_MASK;
		if (p.phase_start) begin
			if (!p.leftward) begin
				run_level  = '0;
				peak_score = '0;
				best_x_lo  = xp;
				best_x_hi  = xp;
				best_y_lo  = yp;
				rev_strand = p.reverse_strand;
			end else begin
				run_level = $signed({2'b00, peak_score});
			end
		end
		// Skip the pair once the score has dropped below zero
		if (run_level >= 0) begin
			y_cmp = rev_strand ? opposite_base(p.y_base) : p.y_base;
			hit = (p.x_base != BASE_N) && (p.y_base != BASE_N) && (p.x_base == y_cmp);
			if (hit) begin
				if (run_level < $signed(RUN_MAX))
					run_level = run_level + 1;
			end else begin
				run_level = run_level - 1;
			end
			// Ties go to the later position
			if (run_level >= 0 && run_level >= $signed({2'b00, peak_score})) begin
				peak_score = (run_level[RUN_W-1:32] != '0) ? 32'hFFFF_FFFF : run_level[31:0];
				if (!p.leftward) begin
					best_x_hi = xp;
					if (rev_strand)
						best_y_lo = yp;
				end else begin
					best_x_lo = xp;
					if (!rev_strand)
						best_y_lo = yp;
				end
			end
		end
		if (p.phase_end && p.leftward) begin
			s.seg_x_start = best_x_lo;
			s.seg_y_start = best_y_lo;
			s.seg_length  = best_x_hi - best_x_lo + 32'd1;
			s.seg_score   = peak_score;
			segs_due.push_back(s);
		end
	endtask

	task automatic note_failure(input string msg);
		if (mismatches < 10)
			$display("[%0t] segment mismatch:%s", $realtime, msg);
		mismatches++;
	endtask

	// Check segments first, then feed the model with the pair of this edge
	always @(posedge clk or negedge arst_n) begin
		seg_t  want;
		string diff;
		if (!arst_n) begin
			run_level    = '0;
			peak_score   = '0;
			best_x_lo    = '0;
			best_x_hi    = '0;
			best_y_lo    = '0;
			rev_strand   = 1'b0;
			segs_due.delete();
			mismatches   = 0;
			segs_pending = 0;
		end else begin
			if (seg_valid && seg_ready) begin
				if (segs_due.size() == 0) begin
					note_failure($sformatf(
						" unexpected transaction x_start %0d y_start %0d len %0d score %0d",
						seg.seg_x_start, seg.seg_y_start, seg.seg_length, seg.seg_score));
				end else begin
					want = segs_due.pop_front();
					diff = "";
					if (seg.seg_x_start !== want.seg_x_start)
						diff = {diff, $sformatf(" x_start exp %0d got %0d",
							want.seg_x_start, seg.seg_x_start)};
					if (seg.seg_y_start !== want.seg_y_start)
						diff = {diff, $sformatf(" y_start exp %0d got %0d",
							want.seg_y_start, seg.seg_y_start)};
					if (seg.seg_length !== want.seg_length)
						diff = {diff, $sformatf(" length exp %0d got %0d",
							want.seg_length, seg.seg_length)};
					if (seg.seg_score !== want.seg_score)
						diff = {diff, $sformatf(" score exp %0d got %0d",
							want.seg_score, seg.seg_score)};
					if (diff != "")
						note_failure(diff);
				end
			end
			if (pair_valid && pair_ready)
				extend_diagonal(pair);
			segs_pending = segs_due.size();
		end
	end

endmodule

// ----- tb/sv/ungapped_seed_extension_top_test.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Ungapped seed extension testbench
// Streams directed corner cases, then random seed extensions (mostly
// well-formed rightward and leftward phases, some broken ones and noise)
// with random gaps and output stalls. A checker beside the block predicts
// and compares every segment.
// ----------------------------------------------------------------------------
module ungapped_seed_extension_top_test;
	import usext_pkg::*;

	localparam int PAIR_TARGET = 1750;
	localparam int CYCLE_LIMIT = 2000000;

	logic  clk;
	logic  arst_n     = 1'b0;
	logic  pair_valid = 1'b0;
	logic  pair_ready;
	pair_t pair       = '0;
	logic  seg_valid;
	logic  seg_ready  = 1'b0;
	seg_t  seg;

	int mismatches;
	int segs_pending;
	int cycles     = 0;
	int pairs_sent = 0;
	bit steady     = 1'b0;
	int match_pct  = 70;

	ungapped_seed_extension_top dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.pair_valid (pair_valid),
		.pair_ready (pair_ready),
		.pair       (pair),
		.seg_valid  (seg_valid),
		.seg_ready  (seg_ready),
		.seg        (seg)
	);

	ungapped_seed_extension_checker chk (
		.clk          (clk),
		.arst_n       (arst_n),
		.pair_valid   (pair_valid),
		.pair_ready   (pair_ready),
		.pair         (pair),
		.seg_valid    (seg_valid),
		.seg_ready    (seg_ready),
		.seg          (seg),
		.mismatches   (mismatches),
		.segs_pending (segs_pending)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Abort a hung run
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	// Idle length: mostly none or short, now and then long
	function automatic int idle_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 50) return 0;
		if (r < 85) return $urandom_range(1, 3);
		if (r < 97) return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic logic [7:0] nucleotide(input int i);
		case (i)
			0:       return BASE_A;
			1:       return BASE_C;
			2:       return BASE_G;
			default: return BASE_T;
		endcase
	endfunction

	function automatic logic [31:0] random_pos();
		int r;
		r = $urandom_range(0, 99);
		if (r < 10) return $urandom_range(0, 40);
		if (r < 20) return 32'hFFFF_FFFF - $urandom_range(0, 40);
		return $urandom;
	endfunction

	function automatic pair_t make_pair(input logic [7:0] xb, input logic [7:0] yb,
			input logic [31:0] xp, input logic [31:0] yp,
			input logic lw, input logic st, input logic ed, input logic rv);
		pair_t p;
		p.x_base         = xb;
		p.y_base         = yb;
		p.x_pos          = xp;
		p.y_pos          = yp;
		p.leftward       = lw;
		p.phase_start    = st;
		p.phase_end      = ed;
		p.reverse_strand = rv;
		return p;
	endfunction

	// Output side: random stalls, sometimes long ready stretches
	initial begin
		int stall;
		@(posedge clk iff arst_n);
		forever begin
			seg_ready <= 1'b1;
			repeat (1 + idle_len()) @(posedge clk);
			stall = idle_len();
			if (stall != 0) begin
				seg_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
		end
	end

	// Offer one pair transaction and hold it until accepted
	task automatic send_pair(input pair_t p);
		int gap;
		gap = steady ? 0 : idle_len();
		if (gap != 0) begin
			pair_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		pair       <= p;
		pair_valid <= 1'b1;
		@(negedge clk);
		while (!pair_ready) @(negedge clk);
		@(posedge clk);
		pairs_sent++;
	endtask

	// Hold off the sender until every queued segment has come out
	task automatic wait_drained();
		pair_valid <= 1'b0;
		@(negedge clk);
		while (segs_pending != 0) @(negedge clk);
		@(posedge clk);
	endtask

	// Bases for one pair, biased toward a match on the given strand
	task automatic random_bases(input logic rv, output logic [7:0] xb, output logic [7:0] yb);
		int r;
		int i;
		r = $urandom_range(0, 99);
		i = $urandom_range(0, 3);
		if (r < match_pct) begin
			xb = nucleotide(i);
			yb = rv ? nucleotide(3 - i) : nucleotide(i);
		end else if (r < match_pct + (100 - match_pct) / 2) begin
			xb = nucleotide(i);
			yb = nucleotide($urandom_range(0, 3));
		end else if ($urandom_range(0, 1) == 1) begin
			xb = $urandom_range(0, 1) ? BASE_N : nucleotide(i);
			yb = BASE_N;
		end else begin
			xb = 8'($urandom_range(0, 255));
			yb = $urandom_range(0, 1) ? xb : 8'($urandom_range(0, 255));
		end
	endtask

	function automatic int phase_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 85) return $urandom_range(1, 16);
		if (r < 97) return $urandom_range(17, 40);
		return $urandom_range(60, 120);
	endfunction

	// Walk outward from the seed in one direction
	task automatic send_phase(input logic lw, input logic [31:0] sx, input logic [31:0] sy,
			input logic rv, input int len, input bit mark_start, input bit mark_end);
		logic [7:0]  xb;
		logic [7:0]  yb;
		logic [31:0] xp;
		logic [31:0] yp;
		logic        rbit;
		for (int k = 0; k < len; k++) begin
			random_bases(rv, xb, yb);
			xp = lw ? sx - 32'(k) : sx + 32'(k);
			yp = (lw ^ rv) ? sy - 32'(k) : sy + 32'(k);
			rbit = (!lw && k == 0) ? rv : 1'($urandom_range(0, 1));
			send_pair(make_pair(xb, yb, xp, yp, lw, mark_start && k == 0,
				mark_end && k == len - 1, rbit));
		end
	endtask

	initial begin
		logic [31:0] sx;
		logic [31:0] sy;
		logic        rv;
		int          kind;
		pair_t       p;

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// Forward strand; N never matches, not even N against N
		send_pair(make_pair(BASE_A, BASE_A, 100, 200, 1'b0, 1'b1, 1'b0, 1'b0));
		send_pair(make_pair(BASE_C, BASE_C, 101, 201, 1'b0, 1'b0, 1'b0, 1'b0));
		send_pair(make_pair(BASE_G, BASE_T, 102, 202, 1'b0, 1'b0, 1'b0, 1'b1));
		send_pair(make_pair(BASE_T, BASE_T, 103, 203, 1'b0, 1'b0, 1'b1, 1'b0));
		send_pair(make_pair(BASE_A, BASE_A, 100, 200, 1'b1, 1'b1, 1'b0, 1'b0));
		send_pair(make_pair(BASE_N, BASE_N, 99, 199, 1'b1, 1'b0, 1'b0, 1'b0));
		send_pair(make_pair(BASE_G, BASE_G, 98, 198, 1'b1, 1'b0, 1'b0, 1'b0));
		send_pair(make_pair(BASE_C, BASE_C, 97, 197, 1'b1, 1'b0, 1'b1, 1'b0));

		// Reverse strand at extreme positions; other characters are their own partner
		send_pair(make_pair(BASE_A, BASE_T, 0, 32'hFFFF_FFFF, 1'b0, 1'b1, 1'b0, 1'b1));
		send_pair(make_pair(BASE_C, BASE_G, 1, 32'hFFFF_FFFE, 1'b0, 1'b0, 1'b0, 1'b0));
		send_pair(make_pair(8'hFF, 8'hFF, 2, 32'hFFFF_FFFD, 1'b0, 1'b0, 1'b0, 1'b0));
		send_pair(make_pair(BASE_N, BASE_N, 3, 32'hFFFF_FFFC, 1'b0, 1'b0, 1'b1, 1'b1));
		send_pair(make_pair(BASE_G, BASE_C, 0, 32'hFFFF_FFFF, 1'b1, 1'b1, 1'b0, 1'b0));
		send_pair(make_pair(BASE_A, BASE_A, 32'hFFFF_FFFF, 0, 1'b1, 1'b0, 1'b0, 1'b0));
		send_pair(make_pair(BASE_T, BASE_A, 32'hFFFF_FFFE, 1, 1'b1, 1'b0, 1'b1, 1'b1));

		// Score below zero: the rest of the phase is skipped, the closing pair still reports
		send_pair(make_pair(8'h00, 8'h01, 50, 60, 1'b0, 1'b1, 1'b0, 1'b0));
		send_pair(make_pair(BASE_A, BASE_A, 51, 61, 1'b0, 1'b0, 1'b1, 1'b0));
		send_pair(make_pair(BASE_C, BASE_C, 50, 60, 1'b1, 1'b1, 1'b0, 1'b0));
		send_pair(make_pair(BASE_A, BASE_G, 49, 59, 1'b1, 1'b0, 1'b0, 1'b0));
		send_pair(make_pair(BASE_A, BASE_C, 48, 58, 1'b1, 1'b0, 1'b0, 1'b0));
		send_pair(make_pair(BASE_G, BASE_G, 47, 57, 1'b1, 1'b0, 1'b1, 1'b0));

		// Inverted segment, then a leftward pair with no phase start
		send_pair(make_pair(BASE_T, BASE_T, 10, 20, 1'b0, 1'b1, 1'b1, 1'b0));
		send_pair(make_pair(BASE_G, BASE_G, 300, 400, 1'b1, 1'b1, 1'b0, 1'b0));
		send_pair(make_pair(BASE_C, BASE_C, 299, 399, 1'b1, 1'b0, 1'b1, 1'b0));
		send_pair(make_pair(BASE_A, BASE_A, 298, 398, 1'b1, 1'b0, 1'b1, 1'b0));
		wait_drained();

		// Random extensions: mostly well-formed, some broken, some noise
		while (pairs_sent < PAIR_TARGET) begin
			steady    = ($urandom_range(0, 6) == 0);
			rv        = 1'($urandom_range(0, 1));
			sx        = random_pos();
			sy        = random_pos();
			match_pct = $urandom_range(35, 95);
			kind      = $urandom_range(0, 19);
			case (kind)
				0: begin
					repeat ($urandom_range(1, 8)) begin
						p = make_pair(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
							$urandom, $urandom, 1'($urandom_range(0, 1)),
							1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
							1'($urandom_range(0, 1)));
						send_pair(p);
					end
				end
				1: send_phase(1, sx, sy, rv, phase_len(), 1, 1);
				2: begin
					send_phase(0, sx, sy, rv, phase_len(), 0, 1);
					send_phase(1, sx, sy, rv, phase_len(), 1, 1);
				end
				3: begin
					send_phase(0, sx, sy, rv, phase_len(), 1, 1);
					send_phase(1, sx, sy, rv, phase_len(), 0, 1);
				end
				4: begin
					send_phase(0, sx, sy, rv, phase_len(), 1, 0);
					send_phase(1, sx, sy, rv, phase_len(), 1, 0);
				end
				default: begin
					send_phase(0, sx, sy, rv, phase_len(), 1, 1);
					send_phase(1, sx, sy, rv, phase_len(), 1, 1);
				end
			endcase
			if ($urandom_range(0, 9) == 0)
				wait_drained();
		end

		// Drain, then give the block time to show any stray segment
		wait_drained();
		repeat (8) @(posedge clk);
		if (mismatches == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
